// ----- rtl/core/dccq_pkg.sv -----
// Shared types, codes and helper functions for the dual class credit queue.
// No dependencies; imported by every module of the block.
package dccq_pkg;

    localparam int OPC_W  = 3;
    localparam int KIND_W = 5;
    localparam int PAY_W  = 32;
    localparam int STAT_W = 3;
    localparam int CLS_W  = 2;
    localparam int CCNT_W = 5;
    localparam int DCNT_W = 7;

    typedef enum logic [OPC_W-1:0] {
        OP_PUSH       = 3'd0,
        OP_POP        = 3'd1,
        OP_RESERVE    = 3'd2,
        OP_RELEASE    = 3'd3,
        OP_PUSH_REPLY = 3'd4
    } t_opcode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_INVALID  = 3'd1,
        ST_FULL     = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_RESFAULT = 3'd4
    } t_status;

    typedef enum logic [CLS_W-1:0] {
        CLS_CONTROL = 2'd0,
        CLS_DATA    = 2'd1,
        CLS_INVALID = 2'd2
    } t_class;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // latch the input word
        logic execute;  // decide, update pointers, access the stores
    } t_cmd;

    function automatic t_class kind_class(input logic [KIND_W-1:0] kind);
        t_class cls;
        if (kind inside {[5'd1:5'd5]}) begin
            cls = CLS_CONTROL;
        end else if (kind inside {[5'd6:5'd16]}) begin
            cls = CLS_DATA;
        end else begin
            cls = CLS_INVALID;
        end
        return cls;
    endfunction

    function automatic logic is_reply(input logic [KIND_W-1:0] kind);
        return kind inside {5'd8, 5'd10, 5'd12, 5'd14, 5'd16};
    endfunction

endpackage

// ----- rtl/core/dccq_ctrl.sv -----
// Controller state machine: sequences capture, execute and result phases.
// Depends on dccq_pkg (t_cmd).
module dccq_ctrl
    import dccq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    output logic o_done,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_EXEC;
                        r_busy  <= 1'b1;
                    end
                end
                S_EXEC: begin
                    r_state <= S_DONE;
                    r_done  <= 1'b1;
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                    r_done  <= 1'b0;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                    r_done  <= 1'b0;
                end
            endcase
        end
    end

    assign busy          = r_busy;
    assign o_done        = r_done;
    assign o_cmd.capture = start && !r_busy;
    assign o_cmd.execute = (r_state == S_EXEC);

endmodule

// ----- rtl/core/dccq_dpath.sv -----
// Datapath: input capture, lane pointers, reservation count and both envelope stores.
// Depends on dccq_pkg (codes, t_cmd, kind helpers).
module dccq_dpath
    import dccq_pkg::*;
#(
    parameter int CONTROL_DEPTH = 16,
    parameter int DATA_DEPTH    = 64,
    parameter int PAYLOAD_BITS  = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [OPC_W-1:0]  i_opcode,
    input  logic              i_lane,
    input  logic [KIND_W-1:0] i_msg_kind,
    input  logic [PAY_W-1:0]  i_msg_payload,
    output logic [STAT_W-1:0] o_status,
    output logic [KIND_W-1:0] o_out_kind,
    output logic [PAY_W-1:0]  o_out_payload,
    output logic [CLS_W-1:0]  o_kind_class,
    output logic [CCNT_W-1:0] o_control_count,
    output logic [DCNT_W-1:0] o_data_count,
    output logic [DCNT_W-1:0] o_reserved_count
);

    localparam int CAW   = (CONTROL_DEPTH > 1) ? $clog2(CONTROL_DEPTH) : 1;
    localparam int DAW   = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
    localparam int CFW   = $clog2(CONTROL_DEPTH + 1);
    localparam int DFW   = $clog2(DATA_DEPTH + 1);
    localparam int CSW   = CFW + 1;
    localparam int DSW   = DFW + 1;
    localparam int ENV_W = KIND_W + PAYLOAD_BITS;

    // Captured input word.
    logic [OPC_W-1:0]  r_opcode;
    logic              r_lane;
    logic [KIND_W-1:0] r_kind;
    logic [PAY_W-1:0]  r_payload;

    // Lane pointers and reservations.
    logic [CAW-1:0] r_chead;
    logic [CFW-1:0] r_cfill;
    logic [DAW-1:0] r_dhead;
    logic [DFW-1:0] r_dfill;
    logic [DFW-1:0] r_holds;

    // Stores and their registered read data.
    logic [ENV_W-1:0] r_cmem [CONTROL_DEPTH];
    logic [ENV_W-1:0] r_dmem [DATA_DEPTH];
    logic [ENV_W-1:0] r_crd;
    logic [ENV_W-1:0] r_drd;

    // Result registers.
    logic [STAT_W-1:0] r_status;
    logic [CLS_W-1:0]  r_class;
    logic              r_popped;
    logic              r_pop_ctrl;

    logic [STAT_W-1:0] n_status;
    logic              c_push, c_pop, d_push, d_pop, hold_inc, hold_dec;
    logic [DSW-1:0]    d_sum;
    logic              d_full, c_full;
    logic [CSW-1:0]    c_tail_ext, c_head_inc;
    logic [DSW-1:0]    d_tail_ext, d_head_inc;
    logic [CAW-1:0]    c_tail, n_chead;
    logic [DAW-1:0]    d_tail, n_dhead;
    logic [63:0]       in_ext;
    logic [ENV_W-1:0]  w_env;
    logic [ENV_W-1:0]  rd_env;
    logic [63:0]       out_ext;

    always_comb begin
        d_sum  = DSW'(r_dfill) + DSW'(r_holds);
        d_full = (d_sum >= DSW'(DATA_DEPTH));
        c_full = (CSW'(r_cfill) >= CSW'(CONTROL_DEPTH));

        c_tail_ext = CSW'(r_chead) + CSW'(r_cfill);
        if (c_tail_ext >= CSW'(CONTROL_DEPTH)) begin
            c_tail_ext = c_tail_ext - CSW'(CONTROL_DEPTH);
        end
        c_tail = c_tail_ext[CAW-1:0];

        d_tail_ext = DSW'(r_dhead) + DSW'(r_dfill);
        if (d_tail_ext >= DSW'(DATA_DEPTH)) begin
            d_tail_ext = d_tail_ext - DSW'(DATA_DEPTH);
        end
        d_tail = d_tail_ext[DAW-1:0];

        c_head_inc = CSW'(r_chead) + CSW'(1);
        n_chead    = (c_head_inc >= CSW'(CONTROL_DEPTH)) ? '0 : c_head_inc[CAW-1:0];
        d_head_inc = DSW'(r_dhead) + DSW'(1);
        n_dhead    = (d_head_inc >= DSW'(DATA_DEPTH)) ? '0 : d_head_inc[DAW-1:0];

        in_ext = 64'(r_payload);
        w_env  = {r_kind, in_ext[PAYLOAD_BITS-1:0]};
    end

    // Decide the operation outcome from the captured word and current pointers.
    always_comb begin
        n_status = ST_OK;
        c_push   = 1'b0;
        c_pop    = 1'b0;
        d_push   = 1'b0;
        d_pop    = 1'b0;
        hold_inc = 1'b0;
        hold_dec = 1'b0;
        case (r_opcode)
            OP_PUSH: begin
                if (r_lane) begin
                    if (c_full) n_status = ST_FULL;
                    else        c_push   = 1'b1;
                end else begin
                    if (d_full) n_status = ST_FULL;
                    else        d_push   = 1'b1;
                end
            end
            OP_POP: begin
                if (r_lane) begin
                    if (r_cfill == '0) n_status = ST_EMPTY;
                    else               c_pop    = 1'b1;
                end else begin
                    if (r_dfill == '0) n_status = ST_EMPTY;
                    else               d_pop    = 1'b1;
                end
            end
            OP_RESERVE: begin
                if (d_full) n_status = ST_FULL;
                else        hold_inc = 1'b1;
            end
            OP_RELEASE: begin
                if (r_holds == '0) n_status = ST_RESFAULT;
                else               hold_dec = 1'b1;
            end
            OP_PUSH_REPLY: begin
                if (!is_reply(r_kind)) begin
                    n_status = ST_INVALID;
                end else if (r_holds == '0) begin
                    n_status = ST_RESFAULT;
                end else begin
                    hold_dec = 1'b1;
                    d_push   = 1'b1;
                end
            end
            default: n_status = ST_INVALID;
        endcase
    end

    // Capture the input word; payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_opcode  <= i_opcode;
            r_lane    <= i_lane;
            r_kind    <= i_msg_kind;
            r_payload <= i_msg_payload;
        end
    end

    // Pointers, reservations and result flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chead    <= '0;
            r_cfill    <= '0;
            r_dhead    <= '0;
            r_dfill    <= '0;
            r_holds    <= '0;
            r_status   <= ST_OK;
            r_class    <= CLS_INVALID;
            r_popped   <= 1'b0;
            r_pop_ctrl <= 1'b0;
        end else if (i_cmd.execute) begin
            r_status   <= n_status;
            r_class    <= kind_class(r_kind);
            r_popped   <= c_pop || d_pop;
            r_pop_ctrl <= c_pop;
            if (c_push) r_cfill <= r_cfill + CFW'(1);
            if (c_pop) begin
                r_cfill <= r_cfill - CFW'(1);
                r_chead <= n_chead;
            end
            if (d_push) r_dfill <= r_dfill + DFW'(1);
            if (d_pop) begin
                r_dfill <= r_dfill - DFW'(1);
                r_dhead <= n_dhead;
            end
            if (hold_inc) r_holds <= r_holds + DFW'(1);
            if (hold_dec) r_holds <= r_holds - DFW'(1);
        end
    end

    // Control store: write at the tail, read the head.
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            if (c_push) r_cmem[c_tail] <= w_env;
            r_crd <= r_cmem[r_chead];
        end
    end

    // Data store: write at the tail, read the head.
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            if (d_push) r_dmem[d_tail] <= w_env;
            r_drd <= r_dmem[r_dhead];
        end
    end

    always_comb begin
        if (!r_popped)      rd_env = '0;
        else if (r_pop_ctrl) rd_env = r_crd;
        else                rd_env = r_drd;
        out_ext = 64'(rd_env[PAYLOAD_BITS-1:0]);
    end

    assign o_status         = r_status;
    assign o_kind_class     = r_class;
    assign o_out_kind       = rd_env[ENV_W-1 -: KIND_W];
    assign o_out_payload    = out_ext[PAY_W-1:0];
    assign o_control_count  = CCNT_W'(r_cfill);
    assign o_data_count     = DCNT_W'(r_dfill);
    assign o_reserved_count = DCNT_W'(r_holds);

endmodule

// ----- rtl/core/dual_class_credit_queue_top.sv -----
// Top level of the dual class credit queue: controller plus datapath.
// Depends on dccq_pkg, dccq_ctrl and dccq_dpath.
//
// Usage:
//   Command channel: drive i_opcode, i_lane, i_msg_kind and i_msg_payload
//   and raise start; the word is taken at the clock edge where start is
//   high and busy is low. busy then stays high until the result is out.
//   Result channel: o_done pulses for exactly one cycle; the status, popped
//   envelope, kind class and the three occupancy counts are valid in that
//   cycle only. The receiver cannot stall, so capture on o_done.
//   Timing: after the accepting edge the controller enters execute and then
//   the result state, where o_done is high; busy falls as it leaves that
//   state, and the next word is accepted from idle, so a word is not taken
//   until the result of the last one is out. Execute does the decision,
//   pointer update and the registered store read together; the result
//   state holds busy high, and the controller then returns to idle.
//   Reset (i_rst_n low, synchronous): pointers, fills and reservations
//   clear, controller returns to idle. Store contents are not cleared;
//   entries are only read once written.
//   Data pushes and reservations share the data lane capacity; control
//   pushes are checked against the control depth alone.
module dual_class_credit_queue_top
    import dccq_pkg::*;
#(
    parameter int CONTROL_DEPTH = 16,
    parameter int DATA_DEPTH    = 64,
    parameter int PAYLOAD_BITS  = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [OPC_W-1:0]  i_opcode,
    input  logic              i_lane,
    input  logic [KIND_W-1:0] i_msg_kind,
    input  logic [PAY_W-1:0]  i_msg_payload,
    output logic              o_done,
    output logic [STAT_W-1:0] o_status,
    output logic [KIND_W-1:0] o_out_kind,
    output logic [PAY_W-1:0]  o_out_payload,
    output logic [CLS_W-1:0]  o_kind_class,
    output logic [CCNT_W-1:0] o_control_count,
    output logic [DCNT_W-1:0] o_data_count,
    output logic [DCNT_W-1:0] o_reserved_count
);

    t_cmd cmd;

    // Sequence each word through capture, execute and result.
    dccq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (cmd)
    );

    // Hold the lanes, stores and result registers.
    dccq_dpath #(
        .CONTROL_DEPTH (CONTROL_DEPTH),
        .DATA_DEPTH    (DATA_DEPTH),
        .PAYLOAD_BITS  (PAYLOAD_BITS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_opcode         (i_opcode),
        .i_lane           (i_lane),
        .i_msg_kind       (i_msg_kind),
        .i_msg_payload    (i_msg_payload),
        .o_status         (o_status),
        .o_out_kind       (o_out_kind),
        .o_out_payload    (o_out_payload),
        .o_kind_class     (o_kind_class),
        .o_control_count  (o_control_count),
        .o_data_count     (o_data_count),
        .o_reserved_count (o_reserved_count)
    );

endmodule

// ----- tb/sv/dual_class_credit_queue_top_tb.sv -----
// Self-checking testbench for dual_class_credit_queue_top: a shadow of both rings and
// the reply reservations predicts every result word; directed and random traffic.
// Depends on dccq_pkg and the RTL of the block; reads no files.
`timescale 1ns / 100ps

module dual_class_credit_queue_top_tb;
    import dccq_pkg::*;

    localparam int  CTL_SLOTS   = 16;
    localparam int  DAT_SLOTS   = 64;
    localparam int  HALF_PERIOD = 6;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  WORD_TARGET = 1350;
    localparam int  SETTLE      = 12;   // extra edges waited after the final drain

    // Opcodes the block does not implement; they must come back as invalid.
    localparam logic [OPC_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OPC_W-1:0] OP_SPARE_MID   = 3'd6;
    localparam logic [OPC_W-1:0] OP_SPARE_LAST  = 3'd7;

    // Kind map: control kinds, data kinds, and the widest kind the port carries.
    localparam logic [KIND_W-1:0] KIND_NONE   = 5'd0;
    localparam logic [KIND_W-1:0] KIND_CTL_LO = 5'd1;
    localparam logic [KIND_W-1:0] KIND_CTL_HI = 5'd5;
    localparam logic [KIND_W-1:0] KIND_DAT_LO = 5'd6;
    localparam logic [KIND_W-1:0] KIND_DAT_HI = 5'd16;
    localparam logic [KIND_W-1:0] KIND_TOP    = 5'd31;

    localparam logic LANE_DATA    = 1'b0;
    localparam logic LANE_CONTROL = 1'b1;

    // Traffic shapes for the random phases.
    localparam int MODE_FILL    = 0;
    localparam int MODE_DRAIN   = 1;
    localparam int MODE_CREDIT  = 2;
    localparam int MODE_MIXED   = 3;

    typedef struct {
        logic [OPC_W-1:0]  opc;
        logic              lane;
        logic [KIND_W-1:0] kind;
        logic [PAY_W-1:0]  pay;
    } cmd_word_t;

    typedef struct {
        t_status           status;
        logic [KIND_W-1:0] kind;
        logic [PAY_W-1:0]  pay;
        t_class            cls;
        int                ctl_count;
        int                dat_count;
        int                holds;
    } outcome_t;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [PAY_W-1:0]  pay;
    } envelope_t;

    // Scoreboard: a shadow copy of both rings plus the queue of predicted outcomes.
    class credit_queue_scoreboard;
        envelope_t ctl_ring[CTL_SLOTS];
        envelope_t dat_ring[DAT_SLOTS];
        int        ctl_head, ctl_fill, dat_head, dat_fill, holds;
        outcome_t  pending[$];
        int        errors;
        int        words_seen;
        int        results_seen;
        int        status_hits[8];

        function t_class class_of(logic [KIND_W-1:0] k);
            if (k >= KIND_CTL_LO && k <= KIND_CTL_HI) return CLS_CONTROL;
            if (k >= KIND_DAT_LO && k <= KIND_DAT_HI) return CLS_DATA;
            return CLS_INVALID;
        endfunction

        // Replies are the even data kinds from 8 up.
        function bit reply_kind(logic [KIND_W-1:0] k);
            return k >= 5'd8 && k <= KIND_DAT_HI && !k[0];
        endfunction

        function void append_data(logic [KIND_W-1:0] k, logic [PAY_W-1:0] p);
            int slot;
            slot = (dat_head + dat_fill) % DAT_SLOTS;
            dat_ring[slot].kind = k;
            dat_ring[slot].pay  = p;
            dat_fill++;
        endfunction

        // Advance the shadow by one accepted word and queue its outcome.
        function void note_command(cmd_word_t w);
            outcome_t o;
            int       slot;
            o.status = ST_OK;
            o.kind   = '0;
            o.pay    = '0;
            o.cls    = class_of(w.kind);
            words_seen++;
            case (w.opc)
                OP_PUSH: begin
                    if (w.lane == LANE_CONTROL) begin
                        if (ctl_fill >= CTL_SLOTS) begin
                            o.status = ST_FULL;
                        end else begin
                            slot = (ctl_head + ctl_fill) % CTL_SLOTS;
                            ctl_ring[slot].kind = w.kind;
                            ctl_ring[slot].pay  = w.pay;
                            ctl_fill++;
                        end
                    end else if (dat_fill + holds >= DAT_SLOTS) begin
                        o.status = ST_FULL;
                    end else begin
                        append_data(w.kind, w.pay);
                    end
                end
                OP_POP: begin
                    if (w.lane == LANE_CONTROL) begin
                        if (ctl_fill == 0) begin
                            o.status = ST_EMPTY;
                        end else begin
                            o.kind   = ctl_ring[ctl_head].kind;
                            o.pay    = ctl_ring[ctl_head].pay;
                            ctl_head = (ctl_head + 1) % CTL_SLOTS;
                            ctl_fill--;
                        end
                    end else if (dat_fill == 0) begin
                        o.status = ST_EMPTY;
                    end else begin
                        o.kind   = dat_ring[dat_head].kind;
                        o.pay    = dat_ring[dat_head].pay;
                        dat_head = (dat_head + 1) % DAT_SLOTS;
                        dat_fill--;
                    end
                end
                OP_RESERVE: begin
                    if (dat_fill + holds >= DAT_SLOTS) o.status = ST_FULL;
                    else holds++;
                end
                OP_RELEASE: begin
                    if (holds == 0) o.status = ST_RESFAULT;
                    else holds--;
                end
                OP_PUSH_REPLY: begin
                    if (!reply_kind(w.kind)) begin
                        o.status = ST_INVALID;
                    end else if (holds == 0) begin
                        o.status = ST_RESFAULT;
                    end else begin
                        holds--;
                        append_data(w.kind, w.pay);
                    end
                end
                default: o.status = ST_INVALID;
            endcase
            o.ctl_count = ctl_fill;
            o.dat_count = dat_fill;
            o.holds     = holds;
            status_hits[o.status]++;
            pending.push_back(o);
        endfunction

        // Compare one result word against the oldest prediction.
        function void check_outcome(logic [STAT_W-1:0] st, logic [KIND_W-1:0] k,
                                    logic [PAY_W-1:0] p, logic [CLS_W-1:0] c,
                                    logic [CCNT_W-1:0] cc, logic [DCNT_W-1:0] dc,
                                    logic [DCNT_W-1:0] rc);
            outcome_t o;
            results_seen++;
            if (pending.size() == 0) begin
                $error("result word with no command outstanding (status %0d)", st);
                errors++;
                return;
            end
            o = pending.pop_front();
            if (st !== o.status) begin
                $error("status: expected %0d, actual %0d", o.status, st);
                errors++;
            end
            if (k !== o.kind) begin
                $error("out_kind: expected %0d, actual %0d", o.kind, k);
                errors++;
            end
            if (p !== o.pay) begin
                $error("out_payload: expected %h, actual %h", o.pay, p);
                errors++;
            end
            if (c !== o.cls) begin
                $error("kind_class: expected %0d, actual %0d", o.cls, c);
                errors++;
            end
            if (cc !== CCNT_W'(o.ctl_count)) begin
                $error("control_count: expected %0d, actual %0d", o.ctl_count, cc);
                errors++;
            end
            if (dc !== DCNT_W'(o.dat_count)) begin
                $error("data_count: expected %0d, actual %0d", o.dat_count, dc);
                errors++;
            end
            if (rc !== DCNT_W'(o.holds)) begin
                $error("reserved_count: expected %0d, actual %0d", o.holds, rc);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [OPC_W-1:0]  i_opcode;
    logic              i_lane;
    logic [KIND_W-1:0] i_msg_kind;
    logic [PAY_W-1:0]  i_msg_payload;
    logic              o_done;
    logic [STAT_W-1:0] o_status;
    logic [KIND_W-1:0] o_out_kind;
    logic [PAY_W-1:0]  o_out_payload;
    logic [CLS_W-1:0]  o_kind_class;
    logic [CCNT_W-1:0] o_control_count;
    logic [DCNT_W-1:0] o_data_count;
    logic [DCNT_W-1:0] o_reserved_count;

    credit_queue_scoreboard scoreboard = new();
    int                     cycle_count = 0;
    int                     words_sent  = 0;

    dual_class_credit_queue_top #(
        .CONTROL_DEPTH (CTL_SLOTS),
        .DATA_DEPTH    (DAT_SLOTS),
        .PAYLOAD_BITS  (PAY_W)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_opcode         (i_opcode),
        .i_lane           (i_lane),
        .i_msg_kind       (i_msg_kind),
        .i_msg_payload    (i_msg_payload),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_out_kind       (o_out_kind),
        .o_out_payload    (o_out_payload),
        .o_kind_class     (o_kind_class),
        .o_control_count  (o_control_count),
        .o_data_count     (o_data_count),
        .o_reserved_count (o_reserved_count)
    );

    initial i_clk = 1'b0;
    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Watch both channels at every edge. The values read here are the ones
    // from before the edge, since the block and the driver update with
    // nonblocking assignments. Check the result before noting a new word;
    // the queue keeps order either way.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) begin
                scoreboard.check_outcome(o_status, o_out_kind, o_out_payload, o_kind_class,
                                         o_control_count, o_data_count, o_reserved_count);
            end
            if (start && !busy) begin
                scoreboard.note_command(cmd_word_t'{i_opcode, i_lane, i_msg_kind,
                                                    i_msg_payload});
            end
        end
    end

    // Watchdog: a stalled handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, scoreboard.pending.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Present one word and hold it until the block takes it. start stays
    // high on return, so a back-to-back word needs no extra edge.
    task automatic send_word(cmd_word_t w);
        start         <= 1'b1;
        i_opcode      <= w.opc;
        i_lane        <= w.lane;
        i_msg_kind    <= w.kind;
        i_msg_payload <= w.pay;
        do @(posedge i_clk); while (busy);
        words_sent++;
    endtask

    // Drop start for the given gap; a gap of zero keeps the stream back to back.
    task automatic idle_for(int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Hold the sender until every predicted result has come back. Step past
    // an edge first so the word accepted at the current edge is already noted.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (scoreboard.pending.size() != 0) @(posedge i_clk);
    endtask

    function automatic int pick_gap(int idle_mode);
        int r;
        r = $urandom_range(0, 99);
        if (idle_mode == 0) return 0;
        if (idle_mode == 1) return (r < 85) ? 0 : $urandom_range(1, 3);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [KIND_W-1:0] pick_kind();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return KIND_W'($urandom_range(KIND_CTL_LO, KIND_CTL_HI));
        if (r < 7) return KIND_W'($urandom_range(KIND_DAT_LO, KIND_DAT_HI));
        return KIND_W'($urandom_range(KIND_NONE, KIND_TOP));
    endfunction

    function automatic logic [KIND_W-1:0] pick_reply_kind();
        if ($urandom_range(0, 9) < 8) return 5'd8 + 5'($urandom_range(0, 4) * 2);
        return KIND_W'($urandom_range(KIND_NONE, KIND_TOP));
    endfunction

    function automatic logic [PAY_W-1:0] pick_payload();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return $urandom();
    endfunction

    // Build one random word. Each mode weights the opcodes differently so
    // that the rings fill to the brim, run dry, or churn reservations.
    function automatic cmd_word_t pick_word(int mode);
        cmd_word_t w;
        int        r;
        int        push_w, pop_w, resv_w, rel_w, reply_w;
        case (mode)
            MODE_FILL:   begin push_w = 48; pop_w = 18; resv_w = 14; rel_w = 5;  reply_w = 12; end
            MODE_DRAIN:  begin push_w = 15; pop_w = 55; resv_w = 5;  rel_w = 12; reply_w = 10; end
            MODE_CREDIT: begin push_w = 12; pop_w = 10; resv_w = 33; rel_w = 15; reply_w = 27; end
            default:     begin push_w = 28; pop_w = 28; resv_w = 15; rel_w = 12; reply_w = 14; end
        endcase
        r      = $urandom_range(0, 99);
        w.lane = 1'($urandom_range(0, 1));
        w.kind = pick_kind();
        w.pay  = pick_payload();
        if (r < push_w) begin
            w.opc = OP_PUSH;
        end else if (r < push_w + pop_w) begin
            w.opc = OP_POP;
        end else if (r < push_w + pop_w + resv_w) begin
            w.opc = OP_RESERVE;
        end else if (r < push_w + pop_w + resv_w + rel_w) begin
            w.opc = OP_RELEASE;
        end else if (r < push_w + pop_w + resv_w + rel_w + reply_w) begin
            w.opc  = OP_PUSH_REPLY;
            w.kind = pick_reply_kind();
        end else begin
            w.opc = OPC_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        end
        return w;
    endfunction

    initial begin
        cmd_word_t directed[$];
        int        phase_len;
        int        mode;
        int        idle_mode;

        start         <= 1'b0;
        i_opcode      <= OP_PUSH;
        i_lane        <= LANE_DATA;
        i_msg_kind    <= KIND_NONE;
        i_msg_payload <= '0;
        i_rst_n       <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opening: empty pops, faults with no hold, every kind class
        // with payload extremes, a reservation spent on a reply, the spare
        // opcodes, and the lane bit on commands that ignore it.
        directed = '{
            '{OP_POP,        LANE_DATA,    KIND_NONE,   32'h0},
            '{OP_POP,        LANE_CONTROL, KIND_TOP,    32'hFFFF_FFFF},
            '{OP_RELEASE,    LANE_DATA,    KIND_CTL_LO, 32'h0},
            '{OP_PUSH_REPLY, LANE_DATA,    5'd16,       32'h1234_5678},
            '{OP_PUSH_REPLY, LANE_CONTROL, 5'd9,        32'h0},
            '{OP_PUSH,       LANE_CONTROL, KIND_NONE,   32'h0},
            '{OP_PUSH,       LANE_CONTROL, KIND_CTL_HI, 32'hFFFF_FFFF},
            '{OP_PUSH,       LANE_CONTROL, KIND_TOP,    32'hA5A5_5A5A},
            '{OP_PUSH,       LANE_DATA,    KIND_DAT_LO, 32'hFFFF_FFFF},
            '{OP_PUSH,       LANE_DATA,    5'd17,       32'h0},
            '{OP_RESERVE,    LANE_CONTROL, KIND_NONE,   32'h0},
            '{OP_RESERVE,    LANE_DATA,    KIND_TOP,    32'hFFFF_FFFF},
            '{OP_PUSH_REPLY, LANE_CONTROL, 5'd8,        32'hDEAD_BEEF},
            '{OP_RELEASE,    LANE_CONTROL, KIND_DAT_HI, 32'h0},
            '{OP_RELEASE,    LANE_DATA,    KIND_NONE,   32'h0},
            '{OP_SPARE_FIRST, LANE_DATA,   KIND_CTL_LO, 32'h0},
            '{OP_SPARE_MID,  LANE_CONTROL, KIND_DAT_LO, 32'hFFFF_FFFF},
            '{OP_SPARE_LAST, LANE_CONTROL, KIND_TOP,    32'h5555_AAAA},
            '{OP_POP,        LANE_CONTROL, KIND_CTL_LO, 32'h0},
            '{OP_POP,        LANE_CONTROL, KIND_NONE,   32'h0},
            '{OP_POP,        LANE_CONTROL, KIND_DAT_HI, 32'h0},
            '{OP_POP,        LANE_CONTROL, KIND_NONE,   32'h0},
            '{OP_POP,        LANE_DATA,    KIND_NONE,   32'h0},
            '{OP_POP,        LANE_DATA,    KIND_NONE,   32'h0},
            '{OP_POP,        LANE_DATA,    KIND_NONE,   32'h0}
        };
        foreach (directed[i]) begin
            send_word(directed[i]);
            idle_for(pick_gap(i % 3));
        end
        drain_results();

        // Random phases. Each picks a traffic shape and an idle pattern;
        // some end with the sender waiting for every result.
        while (words_sent < WORD_TARGET) begin
            phase_len = $urandom_range(60, 180);
            mode      = $urandom_range(MODE_FILL, MODE_MIXED);
            idle_mode = $urandom_range(0, 2);
            repeat (phase_len) begin
                if (words_sent < WORD_TARGET) begin
                    send_word(pick_word(mode));
                    idle_for(pick_gap(idle_mode));
                end
            end
            if ($urandom_range(0, 2) == 0) drain_results();
        end

        drain_results();
        repeat (SETTLE) @(posedge i_clk);

        $display("covered %0d words and %0d result words over %0d cycles",
                 scoreboard.words_seen, scoreboard.results_seen, cycle_count);
        $display("outcomes: ok %0d, invalid %0d, full %0d, empty %0d, no reservation %0d",
                 scoreboard.status_hits[ST_OK], scoreboard.status_hits[ST_INVALID],
                 scoreboard.status_hits[ST_FULL], scoreboard.status_hits[ST_EMPTY],
                 scoreboard.status_hits[ST_RESFAULT]);
        if (scoreboard.errors == 0 && scoreboard.pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
